### hw/rtl/cconv_pkg.sv
// Package for the circular convolution block: sizes, opcodes, register
// indexes and the beat structs shared by the top level and its datapath.
// No dependencies.
`timescale 1ns / 1ps

package cconv_pkg;

  // Storage sizes.
  localparam int MAX_POINTS  = 64;
  localparam int MAX_HALF    = 31;
  localparam int SAMPLE_BITS = 16;
  localparam int TAP_DEPTH   = 2 * MAX_HALF + 1;

  // Field widths of the beats and the registers.
  localparam int OP_W    = 2;
  localparam int SLOT_W  = 6;
  localparam int VALUE_W = 16;
  localparam int RES_W   = 32;
  localparam int N_W     = 7;
  localparam int M_W     = 5;
  localparam int GAIN_W  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;

  // Address widths of the two stores.
  localparam int SMP_AW = $clog2(MAX_POINTS);
  localparam int TAP_AW = $clog2(TAP_DEPTH);

  // Datapath widths. A product of two samples is exact in PROD_W bits, and a
  // sum of up to TAP_DEPTH of them fits ACC_W. The accumulator is scaled by
  // the gain in two halves through the same multiplier.
  localparam int PROD_W  = 2 * SAMPLE_BITS;
  localparam int ACC_W   = PROD_W + TAP_AW;
  localparam int LO_W    = ACC_W / 2;
  localparam int HI_W    = ACC_W - LO_W;
  localparam int MUL_A_W = (LO_W + 1 > SAMPLE_BITS) ? LO_W + 1 : SAMPLE_BITS;
  localparam int MUL_B_W = (GAIN_W > SAMPLE_BITS) ? GAIN_W : SAMPLE_BITS;
  localparam int MULP_W  = MUL_A_W + MUL_B_W;
  localparam int SCL_W   = ACC_W + GAIN_W;
  localparam int FRAC_SHIFT = 31;

  localparam longint RES_MAX = 64'sd2147483647;
  localparam longint RES_MIN = -64'sd2147483648;

  // Opcodes of an input beat.
  localparam logic [OP_W-1:0] OP_TAP   = 2'd0;
  localparam logic [OP_W-1:0] OP_SMP   = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;

  // Register indexes of the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd2;

  // Reset values of the registers.
  localparam logic [N_W-1:0]           POINTS_RST = N_W'(MAX_POINTS);
  localparam logic [M_W-1:0]           HALF_RST   = '0;
  localparam logic signed [GAIN_W-1:0] GAIN_RST   = 24'sd65536;

  // What the shared multiplier works on in a cycle.
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_MAC,
    MUL_LO,
    MUL_HI
  } cconv_mul_e;

  typedef struct packed {
    logic [OP_W-1:0]           opcode;
    logic [SLOT_W-1:0]         slot;
    logic signed [VALUE_W-1:0] value;
  } cconv_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result;
    logic [SLOT_W-1:0]       position;
    logic                    final_res;
  } cconv_out_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    cconv_mul_e        mul_sel;
    logic              acc_clr;
    logic [SMP_AW-1:0] pos;
    logic              last;
  } cconv_ctrl_t;

endpackage

### hw/rtl/cconv_mac.sv
// Datapath of the circular convolution block: the shared multiplier, the
// accumulator, the two-step gain scaling and the result register.
// Depends on cconv_pkg.
`timescale 1ns / 1ps

module cconv_mac
  import cconv_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cconv_ctrl_t                   ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] smp_i,
  input  logic signed [SAMPLE_BITS-1:0] tap_i,
  input  logic signed [GAIN_W-1:0]      gain_i,
  output logic                          pending_o,
  output logic                          res_valid_o,
  output cconv_out_t                    res_o
);

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MULP_W-1:0]  prod_d, prod_q;
  cconv_mul_e                kind_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [HI_W-1:0]    acc_hi;
  logic signed [SCL_W-1:0]   scl_q;
  logic signed [SCL_W-1:0]   scl_sum;
  logic signed [SCL_W-1:0]   scl_shr;
  logic signed [RES_W-1:0]   res_sat;
  logic                      res_valid_q;
  cconv_out_t                res_q;

  assign acc_hi = acc_q[ACC_W-1:LO_W];

  always_comb begin
    unique case (ctrl_i.mul_sel)
      MUL_MAC: begin
        mul_a = MUL_A_W'(smp_i);
        mul_b = MUL_B_W'(tap_i);
      end
      MUL_LO: begin
        mul_a = signed'(MUL_A_W'({1'b0, acc_q[LO_W-1:0]}));
        mul_b = MUL_B_W'(gain_i);
      end
      MUL_HI: begin
        mul_a = MUL_A_W'(acc_hi);
        mul_b = MUL_B_W'(gain_i);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = MULP_W'(mul_a) * MULP_W'(mul_b);

  // The upper half of the scaled sum joins the lower half, then the Q.46
  // value is floored back to Q.15 and clamped to the 32-bit range.
  assign scl_sum = scl_q + (SCL_W'(prod_q) <<< LO_W);
  assign scl_shr = scl_sum >>> FRAC_SHIFT;

  always_comb begin
    priority if (scl_shr > SCL_W'(RES_MAX)) begin
      res_sat = RES_W'(RES_MAX);
    end else if (scl_shr < SCL_W'(RES_MIN)) begin
      res_sat = RES_W'(RES_MIN);
    end else begin
      res_sat = RES_W'(scl_shr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= MUL_NONE;
      res_valid_q <= 1'b0;
    end else begin
      kind_q      <= ctrl_i.mul_sel;
      res_valid_q <= (kind_q == MUL_HI);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (kind_q == MUL_MAC) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (kind_q == MUL_LO) begin
      scl_q <= SCL_W'(prod_q);
    end
    if (kind_q == MUL_HI) begin
      res_q.result    <= res_sat;
      res_q.position  <= SLOT_W'(ctrl_i.pos);
      res_q.final_res <= ctrl_i.last;
    end
  end

  assign pending_o   = (kind_q != MUL_NONE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### hw/rtl/circular_convolution.sv
// Top level of the circular convolution block: command port, configuration
// registers, sample and tap memories and the run sequencer.
// Depends on cconv_pkg and cconv_mac.
`timescale 1ns / 1ps

// A command beat writes a kernel tap, writes a sample, or starts a run. Tap
// and sample writes never raise busy_o, so while busy_o is low a stream
// of loads goes in at one beat per clock. A start beat raises busy_o for the
// whole run and produces point_count results, one per output sample, in
// order of position; the last carries final_res. There is a single 20 x 24
// multiplier, so each result takes one multiply-accumulate per kernel tap,
// then a pipeline drain and gain scaling in two halves. Before the first
// result the run reduces M modulo n by repeated subtraction. Each result is
// shown on res_o for exactly one cycle with res_valid_o high and cannot be
// held off; the receiver must take it then. busy_o falls in the same cycle
// that the last result appears, so the next command may be issued there.
// Configuration writes are taken only while busy_o is low.
module circular_convolution
  import cconv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  cconv_in_t             cmd_i,
  output logic                  busy_o,
  output logic                  res_valid_o,
  output cconv_out_t            res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD   = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_SCLO  = 3'd4;
  localparam logic [2:0] ST_SCHI  = 3'd5;
  localparam logic [2:0] ST_WAIT  = 3'd6;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [N_W-1:0]           cfg_n_q;
  logic [M_W-1:0]           cfg_m_q;
  logic signed [GAIN_W-1:0] gain_q;

  // Run registers: clamped point count, half width, the modulo remainder,
  // the first sample index of the current output, the walking sample and
  // tap indexes, and the output position.
  logic [N_W-1:0]    n_q, n_d;
  logic [M_W-1:0]    m_q, m_d;
  logic [M_W-1:0]    r_q, r_d;
  logic [SMP_AW-1:0] base_q, base_d;
  logic [SMP_AW-1:0] idx_q, idx_d;
  logic [TAP_AW-1:0] t_q, t_d;
  logic [SMP_AW-1:0] k_q, k_d;
  logic              rd_vld_q;

  logic              cmd_acc;
  logic              cfg_acc;
  logic              rd_en;
  logic              acc_clr;
  logic              pending;
  logic [N_W-1:0]    n_clamp;
  logic [SMP_AW-1:0] n_last;
  logic [TAP_AW-1:0] t_last;
  logic              k_is_last;
  logic              r_ge_n;
  cconv_mul_e        mul_sel;
  cconv_ctrl_t       ctrl;

  logic signed [SAMPLE_BITS-1:0] smp_mem [MAX_POINTS];
  logic signed [SAMPLE_BITS-1:0] tap_mem [TAP_DEPTH];
  logic signed [SAMPLE_BITS-1:0] smp_rd_q;
  logic signed [SAMPLE_BITS-1:0] tap_rd_q;

  assign busy_o      = (state_q != ST_IDLE);
  assign cmd_acc     = start_i && !busy_o;
  assign cfg_ready_o = !busy_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_n_q <= POINTS_RST;
      cfg_m_q <= HALF_RST;
      gain_q  <= GAIN_RST;
    end else if (cfg_acc) begin
      unique case (cfg_index_i)
        CFG_POINTS: cfg_n_q <= cfg_data_i[N_W-1:0];
        CFG_HALF:   cfg_m_q <= cfg_data_i[M_W-1:0];
        CFG_GAIN:   gain_q  <= signed'(cfg_data_i[GAIN_W-1:0]);
        default:    ;
      endcase
    end
  end

  // A point count of zero acts as one, and anything above the memory depth
  // acts as the full depth.
  always_comb begin
    priority if (cfg_n_q == '0) begin
      n_clamp = N_W'(1);
    end else if (cfg_n_q > N_W'(MAX_POINTS)) begin
      n_clamp = N_W'(MAX_POINTS);
    end else begin
      n_clamp = cfg_n_q;
    end
  end

  // ---------------------------------------------------------------------
  // Memories. Writes come straight from command beats; reads are issued by
  // the sequencer one tap per cycle and land in registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (cmd_acc && (cmd_i.opcode == OP_SMP)) begin
      smp_mem[cmd_i.slot] <= SAMPLE_BITS'(cmd_i.value);
    end
    if (rd_en) begin
      smp_rd_q <= smp_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc && (cmd_i.opcode == OP_TAP) && ({1'b0, cmd_i.slot} < (SLOT_W + 1)'(TAP_DEPTH)))
    begin
      tap_mem[TAP_AW'(cmd_i.slot)] <= SAMPLE_BITS'(cmd_i.value);
    end
    if (rd_en) begin
      tap_rd_q <= tap_mem[t_q];
    end
  end

  // ---------------------------------------------------------------------
  // Run sequencer.
  //
  // Output k needs samples (k + M - t) mod n for tap slots t = 0..2M. The
  // start index (k + M) mod n is found once per run for k = 0 by repeated
  // subtraction, then advances by one with wrap for each output. Within an
  // output the sample index steps down by one with wrap, so no divider is
  // needed anywhere.
  // ---------------------------------------------------------------------
  assign n_last    = SMP_AW'(n_q - N_W'(1));
  assign t_last    = {m_q, 1'b0};
  assign k_is_last = (k_q == n_last);
  assign r_ge_n    = ({{(N_W - M_W){1'b0}}, r_q} >= n_q);

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    m_d     = m_q;
    r_d     = r_q;
    base_d  = base_q;
    idx_d   = idx_q;
    t_d     = t_q;
    k_d     = k_q;
    rd_en   = 1'b0;
    acc_clr = 1'b0;
    mul_sel = MUL_NONE;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_acc && (cmd_i.opcode == OP_START)) begin
          n_d     = n_clamp;
          m_d     = cfg_m_q;
          r_d     = cfg_m_q;
          k_d     = '0;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (r_ge_n) begin
          r_d = r_q - M_W'(n_q);
        end else begin
          base_d  = SMP_AW'(r_q);
          idx_d   = SMP_AW'(r_q);
          t_d     = '0;
          acc_clr = 1'b1;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        rd_en = 1'b1;
        if (t_q == t_last) begin
          state_d = ST_DRAIN;
        end else begin
          t_d   = t_q + TAP_AW'(1);
          idx_d = (idx_q == '0) ? n_last : idx_q - SMP_AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !pending) begin
          state_d = ST_SCLO;
        end
      end
      ST_SCLO: begin
        mul_sel = MUL_LO;
        state_d = ST_SCHI;
      end
      ST_SCHI: begin
        mul_sel = MUL_HI;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        // The datapath registers this output at the end of this cycle.
        if (k_is_last) begin
          state_d = ST_IDLE;
        end else begin
          k_d     = k_q + SMP_AW'(1);
          base_d  = (base_q == n_last) ? '0 : base_q + SMP_AW'(1);
          idx_d   = (base_q == n_last) ? '0 : base_q + SMP_AW'(1);
          t_d     = '0;
          acc_clr = 1'b1;
          state_d = ST_MAC;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Registered read data feeds the multiplier in the cycle after the read.
    if (rd_vld_q) begin
      mul_sel = MUL_MAC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    m_q    <= m_d;
    r_q    <= r_d;
    base_q <= base_d;
    idx_q  <= idx_d;
    t_q    <= t_d;
    k_q    <= k_d;
  end

  assign ctrl.mul_sel = mul_sel;
  assign ctrl.acc_clr = acc_clr;
  assign ctrl.pos     = k_q;
  assign ctrl.last    = k_is_last;

  cconv_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .smp_i       (smp_rd_q),
    .tap_i       (tap_rd_q),
    .gain_i      (gain_q),
    .pending_o   (pending),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

`ifndef SYNTHESIS
  // A result strobe always follows the final scaling step of an output.
  a_res_after_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q == ST_WAIT))
    else $error("result strobe without a completed scaling step");

  // The walking sample index stays inside the period.
  a_idx_in_period : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> ({1'b0, idx_q} < n_q))
    else $error("sample index outside the period");

  // The tap index never runs past the last kernel slot.
  a_tap_in_kernel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (t_q <= t_last))
    else $error("tap index past the kernel");

  // The last result of a run leaves the block ready for the next command.
  a_final_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.final_res) |-> !busy_o)
    else $error("busy after the last result of a run");
`endif

endmodule

### sim/circular_convolution_tb.sv
// Self-checking testbench for the circular convolution block: drives command
// and register beats, predicts every result and checks each one as it leaves.
// Depends on cconv_pkg and the circular_convolution RTL.
`timescale 1ns / 1ps

module circular_convolution_tb;
  import cconv_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int GAP_PERCENT   = 17;
  localparam int MAX_PRINTS    = 40;
  localparam int RUN_LIMIT_NS  = 50_000_000;

  // The opcode that the package leaves unnamed; the block must ignore it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic signed [GAIN_W-1:0]  GAIN_MAX = 24'sh7FFFFF;
  localparam logic signed [GAIN_W-1:0]  GAIN_MIN = 24'sh800000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX  = 16'sh7FFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN  = 16'sh8000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start_i;
  cconv_in_t             cmd_i;
  logic                  busy_o;
  logic                  res_valid_o;
  cconv_out_t            res_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Shadow copy of the block's state, kept up to date as beats are accepted.
  logic signed [SAMPLE_BITS-1:0] smp_mem [MAX_POINTS];
  logic signed [SAMPLE_BITS-1:0] tap_mem [TAP_DEPTH];
  logic [N_W-1:0]                cfg_points;
  logic [M_W-1:0]                cfg_half;
  logic signed [GAIN_W-1:0]      cfg_gain;

  // Convolution outputs still to come, oldest first.
  cconv_out_t conv_results_q [$];

  int error_count;
  int print_count;
  bit gaps_on;

  circular_convolution u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // A point count of zero behaves as one, and anything past the store depth
  // behaves as the full store.
  function automatic int eff_points(input logic [N_W-1:0] n);
    if (n == 0) return 1;
    if (n > MAX_POINTS) return MAX_POINTS;
    return int'(n);
  endfunction

  // One run: y[k] = gain * sum_j x[(k-j) mod n] * h[j], scaled back by 2^31
  // with a floor shift and clamped to 32 bits.
  function automatic void compute_run();
    int         n;
    int         m;
    int         k;
    int         j;
    int         idx;
    longint     acc;
    longint     scaled;
    cconv_out_t r;
    n = eff_points(cfg_points);
    m = (cfg_half > MAX_HALF) ? MAX_HALF : int'(cfg_half);
    for (k = 0; k < n; k++) begin
      acc = 0;
      for (j = -m; j <= m; j++) begin
        // True modulo: the SV remainder truncates toward zero like C does.
        idx = ((k - j) % n + n) % n;
        acc += longint'(smp_mem[idx]) * longint'(tap_mem[j + m]);
      end
      scaled = (acc * longint'(cfg_gain)) >>> FRAC_SHIFT;
      if (scaled > RES_MAX) scaled = RES_MAX;
      if (scaled < RES_MIN) scaled = RES_MIN;
      r.result    = scaled[RES_W-1:0];
      r.position  = k[SLOT_W-1:0];
      r.final_res = (k == n - 1);
      conv_results_q.push_back(r);
    end
  endfunction

  function automatic void apply_cmd(input cconv_in_t c);
    case (c.opcode)
      OP_TAP: begin
        // Slot 63 lies past the tap store and is dropped.
        if (c.slot < TAP_DEPTH) tap_mem[c.slot] = c.value;
      end
      OP_SMP: begin
        if (c.slot < MAX_POINTS) smp_mem[c.slot] = c.value;
      end
      OP_START: begin
        compute_run();
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    error_count++;
    if (print_count < MAX_PRINTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, what);
      print_count++;
    end
  endtask

  // Results cannot be held off, so every strobe is a beat taken at this edge.
  always @(posedge clk_i) begin
    cconv_out_t want;
    if (rst_ni && res_valid_o) begin
      if (conv_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d at position %0d",
                                  res_o.result, res_o.position));
      end else begin
        want = conv_results_q.pop_front();
        if (res_o.result !== want.result)
          report_mismatch($sformatf("position %0d: result %0d, expected %0d",
                                    want.position, res_o.result, want.result));
        if (res_o.position !== want.position)
          report_mismatch($sformatf("position %0d, expected %0d",
                                    res_o.position, want.position));
        if (res_o.final_res !== want.final_res)
          report_mismatch($sformatf("position %0d: last flag %0b, expected %0b",
                                    want.position, res_o.final_res, want.final_res));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Sends one command beat. start_i is left high after the beat so that a
  // following beat can go out on the next edge; anything that waits lowers it.
  task automatic send_cmd(input cconv_in_t c);
    while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= c;
    do @(posedge clk_i); while (busy_o);
    apply_cmd(c);
  endtask

  // Holds the sender until every predicted result has come out, then lets the
  // block settle.
  task automatic wait_drained();
    start_i <= 1'b0;
    while (conv_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register beat; valid stays high so beats can follow back to back.
  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Registers change only while the block is idle.
  task automatic set_regs(input logic [N_W-1:0] n, input logic [M_W-1:0] m,
                          input logic signed [GAIN_W-1:0] g);
    wait_drained();
    cfg_beat(CFG_POINTS, CFG_DATA_W'(n));
    cfg_points = n;
    cfg_beat(CFG_HALF, CFG_DATA_W'(m));
    cfg_half = m;
    cfg_beat(CFG_GAIN, g);
    cfg_gain = g;
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------

  function automatic cconv_in_t make_cmd(input logic [OP_W-1:0] op, input int slot,
                                         input logic signed [VALUE_W-1:0] v);
    cconv_in_t c;
    c.opcode = op;
    c.slot   = slot[SLOT_W-1:0];
    c.value  = v;
    return c;
  endfunction

  // A well-formed load, mostly inside the current period and inside the kernel,
  // with random data that now and then sits on a rail.
  function automatic cconv_in_t rand_load(input int n_eff, input int m);
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = VAL_MIN;
      1:       v = VAL_MAX;
      default: v = VALUE_W'($urandom);
    endcase
    if ($urandom_range(0, 1)) begin
      // Mostly inside the period; sometimes anywhere in the sample store.
      if ($urandom_range(0, 3) == 0) return make_cmd(OP_SMP, $urandom_range(0, 63), v);
      return make_cmd(OP_SMP, $urandom_range(0, n_eff - 1), v);
    end
    return make_cmd(OP_TAP, $urandom_range(0, 2 * m), v);
  endfunction

  // Beats the block has to ignore: the spare opcode and the tap slot past the end.
  function automatic cconv_in_t rand_noise();
    if ($urandom_range(0, 1))
      return make_cmd(OP_UNUSED, $urandom_range(0, 63), VALUE_W'($urandom));
    return make_cmd(OP_TAP, TAP_DEPTH, VALUE_W'($urandom));
  endfunction

  // The slot and value of a start beat carry no meaning, so they are random.
  function automatic cconv_in_t start_cmd();
    return make_cmd(OP_START, $urandom_range(0, 63), VALUE_W'($urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every store entry gets written first, so no run ever reads an unwritten
  // entry. Then one run with the registers as they come out of reset.
  task automatic test_reset_config();
    int i;
    for (i = 0; i < MAX_POINTS; i++) send_cmd(make_cmd(OP_SMP, i, VALUE_W'($urandom)));
    for (i = 0; i < TAP_DEPTH; i++) send_cmd(make_cmd(OP_TAP, i, VALUE_W'($urandom)));
    send_cmd(start_cmd());
  endtask

  task automatic test_extremes();
    // Widest kernel on the full period at the top gain, with rail values at
    // both ends of both stores and the two beats that must be ignored.
    set_regs(N_W'(MAX_POINTS), M_W'(MAX_HALF), GAIN_MAX);
    send_cmd(make_cmd(OP_SMP, 0, VAL_MIN));
    send_cmd(make_cmd(OP_SMP, 63, VAL_MAX));
    send_cmd(make_cmd(OP_TAP, 0, VAL_MIN));
    send_cmd(make_cmd(OP_TAP, 62, VAL_MAX));
    send_cmd(make_cmd(OP_TAP, 31, VAL_MIN));
    send_cmd(make_cmd(OP_TAP, TAP_DEPTH, VAL_MAX));
    send_cmd(make_cmd(OP_UNUSED, 63, VAL_MAX));
    send_cmd(start_cmd());
    // Single-point period under the widest kernel: every tap wraps onto x[0].
    set_regs(7'd1, M_W'(MAX_HALF), GAIN_MIN);
    send_cmd(start_cmd());
    // A point count of zero acts as one; zero gain clears everything.
    set_regs(7'd0, 5'd5, '0);
    send_cmd(start_cmd());
    // A point count past the store acts as the full store; gain of -1 LSB
    // exercises the floor shift on tiny products.
    set_regs(7'd127, 5'd0, -24'sd1);
    send_cmd(start_cmd());
    // Largest positive sums: all operands at the negative rail.
    set_regs(7'd2, 5'd1, GAIN_MAX);
    send_cmd(make_cmd(OP_SMP, 0, VAL_MIN));
    send_cmd(make_cmd(OP_SMP, 1, VAL_MIN));
    send_cmd(make_cmd(OP_TAP, 0, VAL_MIN));
    send_cmd(make_cmd(OP_TAP, 1, VAL_MIN));
    send_cmd(make_cmd(OP_TAP, 2, VAL_MIN));
    send_cmd(start_cmd());
  endtask

  // Each phase picks a setting, then sends bursts of loads closed by a start.
  // Small periods and kernels dominate to keep the runs short.
  task automatic test_random_phases();
    int                       ph;
    int                       sent;
    int                       burst;
    int                       n_eff;
    logic [N_W-1:0]           n;
    logic [M_W-1:0]           m;
    logic signed [GAIN_W-1:0] g;
    for (ph = 0; ph < 6; ph++) begin
      n = ($urandom_range(0, 3) == 0) ? N_W'($urandom_range(0, 127))
                                      : N_W'($urandom_range(1, 16));
      m = ($urandom_range(0, 4) == 0) ? M_W'($urandom_range(0, 31))
                                      : M_W'($urandom_range(0, 6));
      if ($urandom_range(0, 3) == 0) g = GAIN_W'($urandom);
      else g = GAIN_W'(int'($urandom_range(0, 131072)) - 65536);
      set_regs(n, m, g);
      n_eff = eff_points(n);
      sent  = 0;
      while (sent < 20) begin
        burst = $urandom_range(0, 6);
        repeat (burst) begin
          send_cmd(rand_load(n_eff, int'(m)));
          sent++;
        end
        if ($urandom_range(0, 9) == 0) send_cmd(rand_noise());
        send_cmd(start_cmd());
        sent++;
      end
    end
  endtask

  // No sender gaps at all: loads stream at one beat per clock, and starts,
  // some back to back, sit on busy_o.
  task automatic test_back_to_back();
    int i;
    gaps_on = 1'b0;
    set_regs(7'd5, 5'd2, GAIN_W'($urandom));
    for (i = 0; i < 30; i++) begin
      if ($urandom_range(0, 3) == 0) send_cmd(start_cmd());
      else send_cmd(rand_load(5, 2));
    end
    send_cmd(start_cmd());
    gaps_on = 1'b1;
  endtask

  // The sender stops mid-stream until the block has emptied, then carries on.
  task automatic test_drain_pause();
    int i;
    set_regs(7'd12, 5'd3, -24'sd40000);
    for (i = 0; i < 6; i++) send_cmd(rand_load(12, 3));
    send_cmd(start_cmd());
    wait_drained();
    send_cmd(start_cmd());
    for (i = 0; i < 4; i++) send_cmd(rand_load(12, 3));
    send_cmd(start_cmd());
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    int i;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    cmd_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_POINTS;
    cfg_data_i  = '0;
    error_count = 0;
    print_count = 0;
    gaps_on     = 1'b1;
    for (i = 0; i < MAX_POINTS; i++) smp_mem[i] = '0;
    for (i = 0; i < TAP_DEPTH; i++) tap_mem[i] = '0;
    cfg_points = POINTS_RST;
    cfg_half   = HALF_RST;
    cfg_gain   = GAIN_RST;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_config();
    test_extremes();
    test_random_phases();
    test_back_to_back();
    test_drain_pause();
    wait_drained();

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // A hung handshake or a missing result ends up here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
